// ----- rtl/core/rifr_pkg.sv -----
// Shared types, constants and CRC helpers for the RS485 I/O frame responder.
package rifr_pkg;

   localparam logic [7:0] ADDR_RESET = 8'hE1;
   localparam logic [7:0] CMD_STATUS = 8'h0A;
   localparam logic [7:0] CMD_SET = 8'h0B;
   localparam int MAX_FRAME_DEFAULT = 256;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [8:0] COUNT_CAP = 9'd511;
   localparam logic [8:0] LEN_STATUS = 9'd6;
   localparam logic [8:0] LEN_SET = 9'd9;
   localparam logic [8:0] LEN_MIN = 9'd6;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [3:0] REPLY_LAST = 4'd10;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
      logic [7:0] input_level_a;
      logic [7:0] input_level_b;
      logic [7:0] input_level_c;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic [7:0] relay_group_a;
      logic [7:0] relay_group_b;
      logic [7:0] relay_group_c;
   } rsp_type;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] input_a;
      logic [7:0] input_b;
      logic [7:0] input_c;
      logic [7:0] relay_a;
      logic [7:0] relay_b;
      logic [7:0] relay_c;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] d;
      d = {4'h0, n};
      if (n < 4'd10) begin
         return 8'h30 + d;
      end
      return 8'h37 + d;
   endfunction

endpackage

// ----- rtl/core/rifr_front.sv -----
// Front end: frame intake, CRC check, command decode, relay state and job push.
module rifr_front
   import rifr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   input  logic       queue_full,
   output push_type   push_out
);

   localparam int LenLimitInt = (MAX_FRAME < 510) ? MAX_FRAME : 510;
   localparam logic [8:0] LenLimit = LenLimitInt[8:0];

   logic [7:0]  station_ff;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  tail_ff [4];
   logic [7:0]  tail_in [4];
   logic [8:0]  count_ff, count_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  pay_ff [3];
   logic [7:0]  pay_in [3];
   logic [7:0]  relay_ff [3];
   logic [7:0]  relay_in [3];
   logic        accept, frame_ok, is_status, is_set;
   logic [15:0] crc_fed;
   logic [8:0]  len;

   assign req_stall = queue_full;
   assign accept = req_valid && !req_stall;

   always_comb begin
      crc_fed = (count_ff >= 9'd4) ? crc_feed(crc_ff, tail_ff[0]) : crc_ff;
      len = (count_ff < COUNT_CAP) ? count_ff + 9'd1 : count_ff;
      first_in = first_ff;
      cmd_in = cmd_ff;
      pay_in = pay_ff;
      if (count_ff == 9'd0) begin
         first_in = req_data.rx_byte;
      end else if (count_ff == 9'd1) begin
         cmd_in = req_data.rx_byte;
      end else if (count_ff <= 9'd4) begin
         pay_in[count_ff[1:0] - 2'd2] = req_data.rx_byte;
      end
      frame_ok = (len >= LEN_MIN) && (len <= LenLimit) && (len < COUNT_CAP) &&
                 (first_in == station_ff) &&
                 (tail_ff[1] == hex_digit(crc_fed[15:12])) &&
                 (tail_ff[2] == hex_digit(crc_fed[11:8])) &&
                 (tail_ff[3] == hex_digit(crc_fed[7:4])) &&
                 (req_data.rx_byte == hex_digit(crc_fed[3:0]));
      is_status = frame_ok && (cmd_in == CMD_STATUS) && (len == LEN_STATUS);
      is_set = frame_ok && (cmd_in == CMD_SET) && (len == LEN_SET);
      relay_in = relay_ff;
      if (is_set) begin
         relay_in = pay_in;
      end
      if (req_data.frame_end) begin
         crc_in = CRC_INIT;
         tail_in = '{default: 8'h00};
         count_in = 9'd0;
      end else begin
         crc_in = crc_fed;
         tail_in[0] = tail_ff[1];
         tail_in[1] = tail_ff[2];
         tail_in[2] = tail_ff[3];
         tail_in[3] = req_data.rx_byte;
         count_in = len;
      end
      push_out.push = accept && req_data.frame_end && (is_status || is_set);
      push_out.job.address = station_ff;
      push_out.job.input_a = req_data.input_level_a;
      push_out.job.input_b = req_data.input_level_b;
      push_out.job.input_c = req_data.input_level_c;
      push_out.job.relay_a = relay_in[0];
      push_out.job.relay_b = relay_in[1];
      push_out.job.relay_c = relay_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff <= ADDR_RESET;
         crc_ff <= CRC_INIT;
         tail_ff <= '{default: 8'h00};
         count_ff <= 9'd0;
         first_ff <= 8'h00;
         cmd_ff <= 8'h00;
         pay_ff <= '{default: 8'h00};
         relay_ff <= '{default: 8'h00};
      end else begin
         if (csr_write_enable) begin
            station_ff <= csr_write_data;
         end
         if (accept) begin
            crc_ff <= crc_in;
            tail_ff <= tail_in;
            count_ff <= count_in;
            first_ff <= first_in;
            cmd_ff <= cmd_in;
            pay_ff <= pay_in;
            if (req_data.frame_end) begin
               relay_ff <= relay_in;
            end
         end
      end
   end

endmodule

// ----- rtl/core/rifr_queue.sv -----
// Short job queue between the front end and the reply sender.
module rifr_queue
   import rifr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push_in,
   output logic     full,
   output head_type head,
   input  logic     pop
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [PtrW:0] CountFull = (PtrW + 1)'(DEPTH);

   job_type         entry_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]   count_ff;
   logic            do_pop;

   assign full = (count_ff == CountFull);
   assign head.valid = (count_ff != '0);
   assign head.job = entry_ff[rd_ptr_ff];
   assign do_pop = pop && head.valid;

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push_in.push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_in.push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push_in.push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/core/rifr_back.sv -----
// Reply sender: streams the seven status bytes and appends their CRC as four hex digits.
module rifr_back
   import rifr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [3:0]  idx_ff;
   logic [15:0] crc_ff;
   logic        valid_ff;
   rsp_type     data_ff, data_in;
   logic        load;

   assign load = head.valid && (!valid_ff || !rsp_stall);
   assign pop = load && (idx_ff == REPLY_LAST);
   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

   always_comb begin
      data_in.tx_last = (idx_ff == REPLY_LAST);
      data_in.relay_group_a = head.job.relay_a;
      data_in.relay_group_b = head.job.relay_b;
      data_in.relay_group_c = head.job.relay_c;
      case (idx_ff)
         4'd0: data_in.tx_byte = head.job.address;
         4'd1: data_in.tx_byte = head.job.input_a;
         4'd2: data_in.tx_byte = head.job.input_b;
         4'd3: data_in.tx_byte = head.job.input_c;
         4'd4: data_in.tx_byte = head.job.relay_a;
         4'd5: data_in.tx_byte = head.job.relay_b;
         4'd6: data_in.tx_byte = head.job.relay_c;
         4'd7: data_in.tx_byte = hex_digit(crc_ff[15:12]);
         4'd8: data_in.tx_byte = hex_digit(crc_ff[11:8]);
         4'd9: data_in.tx_byte = hex_digit(crc_ff[7:4]);
         default: data_in.tx_byte = hex_digit(crc_ff[3:0]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 4'd0;
         crc_ff <= CRC_INIT;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
         if (load) begin
            if (idx_ff == REPLY_LAST) begin
               idx_ff <= 4'd0;
               crc_ff <= CRC_INIT;
            end else begin
               idx_ff <= idx_ff + 4'd1;
               if (idx_ff < 4'd7) begin
                  crc_ff <= crc_feed(crc_ff, data_in.tx_byte);
               end
            end
         end
      end
   end

endmodule

// ----- rtl/core/rs485_io_frame_responder.sv -----
// Top level of the RS485 I/O frame responder.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type: received byte, frame end, input groups
//   rsp      out        rsp_valid/rsp_stall  rsp_type: reply byte, last flag, relay groups
//   csr      in         csr_write_enable     station address, 8 bits
//
// The front end takes one received byte per cycle unless the queue is full; its CRC step is
// one byte per cycle. A reply is eleven bytes sent one per cycle from the output register
// unless stalled; a job waits in a two-entry queue, and input stalls only while it is full.
// Reset is synchronous, active high, and clears frame state, relays and the queue.
// A stalled reply holds in the output register; input is taken until the queue fills.
module rs485_io_frame_responder
   import rifr_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   rifr_front #(
      .MAX_FRAME(MAX_FRAME)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .queue_full(queue_full),
      .push_out(push)
   );

   rifr_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_in(push),
      .full(queue_full),
      .head(head),
      .pop(pop)
   );

   rifr_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

// ----- rtl/core/rifr_checker.sv -----
// Port-level assertions for the RS485 I/O frame responder, bound to the top level.
module rifr_checker
   import rifr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input rsp_type    rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("reply valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled reply item changed");

   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.tx_last |=> rsp_valid)
      else $error("gap inside a reply");

   a_relay_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.tx_last |=>
         rsp_data.relay_group_a == $past(rsp_data.relay_group_a) &&
         rsp_data.relay_group_b == $past(rsp_data.relay_group_b) &&
         rsp_data.relay_group_c == $past(rsp_data.relay_group_c))
      else $error("relay groups changed inside a reply");

endmodule

bind rs485_io_frame_responder rifr_checker u_checker (.*);
